FILE: hdl/slew_limited_delta_quantizer_top_defines.svh
// Assertion helpers for the quantizer RTL.
`ifndef SLEW_LIMITED_DELTA_QUANTIZER_TOP_DEFINES_SVH
`define SLEW_LIMITED_DELTA_QUANTIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLDQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sldq: implication check failed");

// Next-cycle implication, disabled during reset.
`define SLDQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sldq: next-cycle check failed");

`endif

FILE: hdl/sldq_pkg.sv
`default_nettype none
package sldq_pkg;

   localparam int CHANNELS   = 2;
   localparam int CH_W       = 1;
   localparam int SAMPLE_W   = 16;
   localparam int OUT_W      = 20;

   localparam int MUL_A_W    = 16;
   localparam int MUL_B_W    = 26;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W  = $clog2(MUL_A_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 26;

   localparam int OSUM_W     = 36;
   localparam logic signed [OSUM_W-1:0] OUT_MAX = 36'sd524287;
   localparam logic signed [OSUM_W-1:0] OUT_MIN = -36'sd524288;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic        [CH_W-1:0]     channel;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_sample;
      logic        [CH_W-1:0]  out_channel;
   } rsp_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] product;
   } mul_res_type;

endpackage
`default_nettype wire

FILE: hdl/slew_limited_delta_quantizer_top.sv
// One item in flight at a time; each item takes two 16-step shift-add
// multiplications (scale down, then scale up) sharing one serial multiplier.
// A finished item waits in the output register while the next one is taken.
// Synchronous active-high reset: state and CSRs to defaults, held levels to zero.
`default_nettype none
`include "slew_limited_delta_quantizer_top_defines.svh"
module slew_limited_delta_quantizer_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire sldq_pkg::req_type         req_payload,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output sldq_pkg::rsp_type              rsp_payload,
   input  wire                            csr_we,
   input  wire [sldq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [sldq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sldq_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DOWN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_UP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEP  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE     = 2'd3;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL1   = 3'd1;
   localparam logic [2:0] ST_LVL    = 3'd2;
   localparam logic [2:0] ST_START2 = 3'd3;
   localparam logic [2:0] ST_MUL2   = 3'd4;
   localparam logic [2:0] ST_FIN    = 3'd5;

   // configuration
   logic [23:0] gain_down_ff;
   logic [25:0] gain_up_ff;
   logic [4:0]  max_step_ff;
   logic [18:0] noise_ff;

   logic [2:0]  state_ff, state_in;
   logic [15:0] held_ff [CHANNELS];
   logic        held_we;
   logic [15:0] held_in;

   logic [CH_W-1:0]    ch_ff, ch_in;
   logic               sneg_ff, sneg_in;
   logic signed [16:0] target_ff, target_in;
   logic signed [16:0] level_ff, level_in;
   logic               zero_ff, zero_in;
   logic               oneg_ff, oneg_in;
   logic [33:0]        omag_ff, omag_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic               accept;
   logic               mul_start;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   mul_res_type        mul_res;

   logic [15:0]        neg_sample;
   logic [14:0]        smag;
   logic [39:0]        tsum;
   logic [15:0]        tmag;
   logic signed [17:0] delta, delta_c, step_pos, step_neg, lsum;
   logic [15:0]        cur_lvl;
   logic [16:0]        lvl_abs;
   logic [MUL_P_W:0]   osum_r;
   logic signed [OSUM_W-1:0] o_base, o_sum;
   logic               out_load;

   sldq_sermul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .res   (mul_res)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      // clamp -32768 to -32767 and split into sign and magnitude
      neg_sample = 16'(-req_payload.sample);
      if (!req_payload.sample[15])
         smag = req_payload.sample[14:0];
      else if (neg_sample[15])
         smag = 15'h7fff;
      else
         smag = neg_sample[14:0];

      lvl_abs   = level_ff[16] ? 17'(-level_ff) : level_ff;
      mul_start = accept || (state_ff == ST_START2);
      if (state_ff == ST_START2) begin
         mul_a = lvl_abs[15:0];
         mul_b = gain_up_ff;
      end else begin
         mul_a = {1'b0, smag};
         mul_b = {2'b00, gain_down_ff};
      end

      // round half away from zero on the magnitude
      tsum = {1'b0, mul_res.product[38:0]} + 40'(24'h800000);
      tmag = tsum[39:24];

      cur_lvl  = held_ff[ch_ff];
      delta    = {target_ff[16], target_ff} - {{2{cur_lvl[15]}}, cur_lvl};
      step_pos = {13'b0, max_step_ff};
      step_neg = -step_pos;
      if (delta > step_pos)
         delta_c = step_pos;
      else if (delta < step_neg)
         delta_c = step_neg;
      else
         delta_c = delta;
      lsum = {{2{cur_lvl[15]}}, cur_lvl} + delta_c;

      osum_r = {1'b0, mul_res.product} + 43'd128;

      o_base = oneg_ff ? -$signed({2'b00, omag_ff}) : $signed({2'b00, omag_ff});
      o_sum  = o_base + (zero_ff ? $signed({17'b0, noise_ff}) : '0);

      state_in  = state_ff;
      ch_in     = ch_ff;
      sneg_in   = sneg_ff;
      target_in = target_ff;
      level_in  = level_ff;
      zero_in   = zero_ff;
      oneg_in   = oneg_ff;
      omag_in   = omag_ff;
      held_we   = 1'b0;
      held_in   = level_ff[15:0] + {15'b0, zero_ff};
      out_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in    = req_payload.channel;
               sneg_in  = req_payload.sample[15];
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            if (mul_res.done) begin
               target_in = sneg_ff ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
               state_in  = ST_LVL;
            end
         end
         ST_LVL: begin
            level_in = lsum[16:0];
            zero_in  = (delta_c == '0);
            state_in = ST_START2;
         end
         ST_START2: begin
            held_we  = 1'b1;
            oneg_in  = level_ff[16];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (mul_res.done) begin
               omag_in  = osum_r[41:8];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_in = rsp_ff;
      if (out_load) begin
         rsp_in.out_channel = ch_ff;
         if (o_sum > OUT_MAX)
            rsp_in.out_sample = OUT_MAX[OUT_W-1:0];
         else if (o_sum < OUT_MIN)
            rsp_in.out_sample = OUT_MIN[OUT_W-1:0];
         else
            rsp_in.out_sample = o_sum[OUT_W-1:0];
      end
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_down_ff <= 24'd1024;
         gain_up_ff   <= 26'd16384;
         max_step_ff  <= 5'd1;
         noise_ff     <= 19'd0;
         for (int i = 0; i < CHANNELS; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (held_we)
            held_ff[ch_ff] <= held_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_DOWN: gain_down_ff <= csr_wdata[23:0];
               CSR_GAIN_UP:   gain_up_ff   <= csr_wdata[25:0];
               CSR_MAX_STEP:  max_step_ff  <= csr_wdata[4:0];
               CSR_NOISE:     noise_ff     <= csr_wdata[18:0];
               default: ;
            endcase
         end
      end
      ch_ff     <= ch_in;
      sneg_ff   <= sneg_in;
      target_ff <= target_in;
      level_ff  <= level_in;
      zero_ff   <= zero_in;
      oneg_ff   <= oneg_in;
      omag_ff   <= omag_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SLDQ_ASSERT_NXT(a_accept_starts_mul, clock, reset, accept, state_ff == ST_MUL1)
   `SLDQ_ASSERT_IMP(a_done_when_waiting, clock, reset, mul_res.done,
                    state_ff == ST_MUL1 || state_ff == ST_MUL2)
   `SLDQ_ASSERT_NXT(a_fin_waits_for_slot, clock, reset,
                    state_ff == ST_FIN && rsp_valid_ff && rsp_stall, state_ff == ST_FIN)

endmodule
`default_nettype wire

FILE: hdl/sldq_sermul.sv
`default_nettype none
module sldq_sermul (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [sldq_pkg::MUL_A_W-1:0]  a,
   input  wire [sldq_pkg::MUL_B_W-1:0]  b,
   output sldq_pkg::mul_res_type        res
);
   import sldq_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_P_W-1:0]   prod_ff, prod_in;
   logic [MUL_B_W-1:0]   b_ff, b_in;
   logic [MUL_B_W:0]     upper;

   // LSB-first shift-add: multiplier bits leave the bottom as product bits enter the top
   always_comb begin
      upper   = {1'b0, prod_ff[MUL_P_W-1:MUL_A_W]}
              + (prod_ff[0] ? {1'b0, b_ff} : {(MUL_B_W+1){1'b0}});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         prod_in = {{MUL_B_W{1'b0}}, a};
         b_in    = b;
      end else if (busy_ff) begin
         prod_in = {upper, prod_ff[MUL_A_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_A_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      prod_ff <= prod_in;
      b_ff    <= b_in;
   end

   assign res.done    = done_ff;
   assign res.product = prod_ff;

endmodule
`default_nettype wire
